[design/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and the control store of the modular exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Program counter of the sequencer, one code per control word
    typedef enum logic [3:0] {
        P_IDLE = 4'd0,
        P_CHKM = 4'd1,
        P_RED  = 4'd2,
        P_INIT = 4'd3,
        P_SQR  = 4'd4,
        P_TST  = 4'd5,
        P_MUL  = 4'd6,
        P_NEXT = 4'd7,
        P_EMIT = 4'd8,
        P_BACK = 4'd9
    } t_pc;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_MUL,
        ACT_INIT,
        ACT_SHIFT,
        ACT_EMIT
    } t_act;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_MZERO,
        C_EBIT0,
        C_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef enum logic [1:0] {
        SRC_ONE,
        SRC_ACC,
        SRC_BASE
    } t_src;

    typedef enum logic {
        DST_ACC,
        DST_BASE
    } t_dst;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_pc   tgt;
        t_src  xsel;
        t_src  ysel;
        t_dst  dst;
    } t_uop;

    // Control store: jump to tgt when cond holds, else fall through
    function automatic t_uop uop_rom(input t_pc pc);
        t_uop u;
        u = '{act: ACT_NONE, cond: C_ALWAYS, tgt: P_IDLE,
              xsel: SRC_ONE, ysel: SRC_ONE, dst: DST_ACC};
        unique case (pc)
            P_IDLE: begin
                u.act  = ACT_LOAD;
                u.cond = C_NO_REQ;
                u.tgt  = P_IDLE;
            end
            P_CHKM: begin
                u.cond = C_MZERO;
                u.tgt  = P_EMIT;
            end
            P_RED: begin
                // base mod m as (1 mod m) * base
                u.act  = ACT_MUL;
                u.cond = C_NEVER;
                u.xsel = SRC_ONE;
                u.ysel = SRC_BASE;
                u.dst  = DST_BASE;
            end
            P_INIT: begin
                u.act  = ACT_INIT;
                u.cond = C_NEVER;
            end
            P_SQR: begin
                u.act  = ACT_MUL;
                u.cond = C_NEVER;
                u.xsel = SRC_ACC;
                u.ysel = SRC_ACC;
                u.dst  = DST_ACC;
            end
            P_TST: begin
                u.cond = C_EBIT0;
                u.tgt  = P_NEXT;
            end
            P_MUL: begin
                u.act  = ACT_MUL;
                u.cond = C_NEVER;
                u.xsel = SRC_ACC;
                u.ysel = SRC_BASE;
                u.dst  = DST_ACC;
            end
            P_NEXT: begin
                u.act  = ACT_SHIFT;
                u.cond = C_MORE;
                u.tgt  = P_SQR;
            end
            P_EMIT: begin
                u.act  = ACT_EMIT;
                u.cond = C_OUT_BUSY;
                u.tgt  = P_EMIT;
            end
            P_BACK: begin
                u.cond = C_ALWAYS;
                u.tgt  = P_IDLE;
            end
            default: begin
                u.cond = C_ALWAYS;
                u.tgt  = P_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

[design/modular_exponentiation_core.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Square-and-multiply modular exponentiation driven by a small microprogram.
// ----------------------------------------------------------------------------
// Computes base ** exponent mod modulus for unsigned WIDTH-bit operands, one
// request at a time. A ten-word control store steps a datapath built around a
// single bit-serial modular multiplier; that multiplier sets the rate. A zero
// modulus goes straight from the modulus check to the output step and
// returns residue zero with modulus_zero set. The result sits in an output
// register, so the next request is taken while it waits to be collected.
// ----------------------------------------------------------------------------
module modular_exponentiation_core
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [WIDTH-1:0] i_base,
    input  logic [WIDTH-1:0] i_exponent,
    input  logic [WIDTH-1:0] i_modulus,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [WIDTH-1:0] o_residue,
    output logic             o_modulus_zero
);

    localparam int MBW = $clog2(WIDTH);
    localparam logic [MBW-1:0] LAST_BIT = MBW'(WIDTH - 1);

    t_pc r_pc, n_pc;

    logic [WIDTH-1:0] r_base, r_exp, r_mod, r_acc, r_macc;
    logic [MBW-1:0]   r_mbit, r_ecnt;
    logic             r_out_valid, r_mzero;
    logic [WIDTH-1:0] r_residue;

    t_uop             uop;
    logic             take, step_done, out_busy, mod_zero;
    logic [WIDTH-1:0] one_mod, mx, my, mres;
    logic [WIDTH+1:0] mt, mm1, mm2;

    assign mod_zero = (r_mod == '0);
    assign one_mod  = {{(WIDTH-1){1'b0}}, (r_mod != {{(WIDTH-1){1'b0}}, 1'b1})};
    assign out_busy = r_out_valid && !i_out_ready;

    // Operand selection for the multiplier
    always_comb begin
        case (uop.xsel)
            SRC_ACC:  mx = r_acc;
            SRC_BASE: mx = r_base;
            default:  mx = one_mod;
        endcase
        case (uop.ysel)
            SRC_ACC:  my = r_acc;
            SRC_BASE: my = r_base;
            default:  my = one_mod;
        endcase
    end

    // One multiplier bit: 2*acc + bit*x is below 3m, so at most 2m comes off
    assign mm1 = {2'b00, r_mod};
    assign mm2 = {1'b0, r_mod, 1'b0};
    assign mt  = {1'b0, r_macc, 1'b0} + (my[r_mbit] ? {2'b00, mx} : '0);

    always_comb begin
        if (mt >= mm2) begin
            mres = WIDTH'(mt - mm2);
        end else if (mt >= mm1) begin
            mres = WIDTH'(mt - mm1);
        end else begin
            mres = WIDTH'(mt);
        end
    end

    // Sequencer: next step and handshake
    always_comb begin
        uop = uop_rom(r_pc);
        unique case (uop.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_REQ:   take = !i_in_valid;
            C_MZERO:    take = mod_zero;
            C_EBIT0:    take = !r_exp[WIDTH-1];
            C_MORE:     take = (r_ecnt != '0);
            C_OUT_BUSY: take = out_busy;
            default:    take = 1'b1;
        endcase
        step_done = (uop.act != ACT_MUL) || (r_mbit == '0);
        if (!step_done) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = uop.tgt;
        end else begin
            n_pc = t_pc'(4'(r_pc) + 4'd1);
        end
        o_in_ready = (r_pc == P_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= P_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbit      <= LAST_BIT;
            r_macc      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (uop.act == ACT_MUL) begin
                if (r_mbit == '0) begin
                    r_mbit <= LAST_BIT;
                    r_macc <= '0;
                end else begin
                    r_mbit <= r_mbit - 1'b1;
                    r_macc <= mres;
                end
            end
            if (uop.act == ACT_EMIT && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        case (uop.act)
            ACT_LOAD: begin
                if (i_in_valid) begin
                    r_base <= i_base;
                    r_exp  <= i_exponent;
                    r_mod  <= i_modulus;
                end
            end
            ACT_MUL: begin
                // write back the product on its last bit
                if (r_mbit == '0) begin
                    if (uop.dst == DST_BASE) begin
                        r_base <= mres;
                    end else begin
                        r_acc <= mres;
                    end
                end
            end
            ACT_INIT: begin
                r_acc  <= one_mod;
                r_ecnt <= LAST_BIT;
            end
            ACT_SHIFT: begin
                r_exp  <= {r_exp[WIDTH-2:0], 1'b0};
                r_ecnt <= r_ecnt - 1'b1;
            end
            ACT_EMIT: begin
                if (!out_busy) begin
                    r_residue <= mod_zero ? '0 : r_acc;
                    r_mzero   <= mod_zero;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_residue      = r_residue;
    assign o_modulus_zero = r_mzero;

endmodule
